// ===== hw/rtl/frlsm_pkg.sv =====
// Shared constants, codes and controller/datapath command types for the slot manager.
`default_nettype none
package frlsm_pkg;

  localparam int SLOTS    = 64;
  localparam int ID_BITS  = 32;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int CNT_W    = SLOT_W + 1;
  localparam int ADDR_W   = SLOT_W + 1;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 3;
  localparam logic [ID_BITS-1:0] ID_ONES = '1;

  typedef enum logic [KIND_W-1:0] {
    K_SAVE   = 3'd0,
    K_LOOKUP = 3'd1,
    K_READ   = 3'd2,
    K_INC    = 3'd3,
    K_FLUSH  = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_PARAM     = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_NO_FLUSH  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_FAIL,
    OP_SAVE,
    OP_LOOK,
    OP_READ,
    OP_INC,
    OP_FLUSH,
    OP_SCAN,
    OP_ERASE
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t code;
  } dp_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              id_ones;
    logic              id_zero;
    logic              idle_zero;
    logic              finish;
    logic              to_erase;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/frlsm_if.sv =====
// Request and response channel interfaces of the slot manager.
`default_nettype none
interface frlsm_req_if import frlsm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [31:0]       record_id;
  logic [CNT_W-1:0]  slot;
  modport source (output valid, kind, record_id, slot, input ready);
  modport sink   (input valid, kind, record_id, slot, output ready);
endinterface

interface frlsm_rsp_if import frlsm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CNT_W-1:0]    result_slot;
  logic                active_region;
  logic [CNT_W-1:0]    occupied_count;
  logic [CNT_W-1:0]    next_idle_slot;
  modport source (output valid, status, result_slot, active_region, occupied_count,
                  next_idle_slot, input ready);
  modport sink   (input valid, status, result_slot, active_region, occupied_count,
                  next_idle_slot, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/flash_record_log_slot_manager.sv =====
// Top level of the record log slot manager: controller plus datapath.
//
//   channel | dir | fields
//   req     | in  | kind, record_id, slot
//   rsp     | out | status, result_slot, active_region, occupied_count, next_idle_slot
//
// One request at a time. Read, increment and rejected requests pass through decode
// straight to the response beat. Save and lookup also scan the slots, reading one
// slot per cycle from memory until the scan hits or runs out. Flush runs a count
// pass, a copy pass and an erase, or only the count pass when no flush is needed.
// Synchronous reset empties both regions at once through per-slot valid bits.
// A stalled response holds the block; the next request is taken after it.
`default_nettype none
module flash_record_log_slot_manager import frlsm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  frlsm_req_if.sink   req,
  frlsm_rsp_if.source rsp
);
  dp_cmd_t  cmd;
  dp_stat_t stat;

  frlsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .out_valid(rsp.valid),
    .out_ready(rsp.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  frlsm_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_kind    (req.kind),
    .in_id      (ID_BITS'(req.record_id)),
    .in_slot    (req.slot),
    .status     (rsp.status),
    .result_slot(rsp.result_slot),
    .region     (rsp.active_region),
    .occupied   (rsp.occupied_count),
    .idle       (rsp.next_idle_slot)
  );
endmodule
`default_nettype wire

// ===== hw/rtl/frlsm_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module frlsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/frlsm_dp.sv =====
// Datapath: slot id memory, valid bits, scan engine and the log state registers.
`default_nettype none
module frlsm_dp import frlsm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [ID_BITS-1:0]  in_id,
  input  logic [CNT_W-1:0]    in_slot,
  output logic [STATUS_W-1:0] status,
  output logic [CNT_W-1:0]    result_slot,
  output logic                region,
  output logic [CNT_W-1:0]    occupied,
  output logic [CNT_W-1:0]    idle
);
  typedef enum logic [1:0] {M_IDLE, M_LOOK, M_COUNT, M_COPY} mode_t;

  // payload of the current item
  logic [KIND_W-1:0]  kind_q;
  logic [ID_BITS-1:0] id_q;
  logic [CNT_W-1:0]   slot_q;
  status_t            status_q;
  logic [CNT_W-1:0]   rslot_q;

  logic               region_q;
  logic [CNT_W-1:0]   occ_q;
  logic [CNT_W-1:0]   idle_q;

  mode_t              mode;
  logic               down;
  logic [CNT_W-1:0]   idx;
  logic               pend;
  logic [SLOT_W-1:0]  pidx;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   wptr;
  logic [2*SLOTS-1:0] vld;
  logic               vld_q;

  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [ID_BITS-1:0] wdata;
  logic [ADDR_W-1:0]  raddr;
  logic [ID_BITS-1:0] ram_q;
  logic [ID_BITS-1:0] eff;
  logic               issue;
  logic               erased;
  logic               match;
  logic               hit;
  logic               scan_end;
  logic               few;
  logic [CNT_W-1:0]   top;
  logic [CNT_W-1:0]   idle_m1;

  frlsm_ram #(.WIDTH(ID_BITS), .DEPTH(2 * SLOTS)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(ram_q)
  );

  assign issue    = !idx[CNT_W-1];
  assign raddr    = {region_q, idx[SLOT_W-1:0]};
  // an entry never written since its region was erased reads as erased
  assign eff      = vld_q ? ram_q : ID_ONES;
  assign erased   = (eff == ID_ONES);
  assign scan_end = !issue && !pend;
  assign few      = (cnt < CNT_W'(SLOTS / 8));
  assign top      = (occ_q > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : occ_q;
  assign idle_m1  = idle_q - CNT_W'(1);

  always_comb begin
    unique case (mode)
      M_IDLE:  match = erased;
      M_LOOK:  match = (eff == id_q);
      M_COUNT: match = erased;
      M_COPY:  match = !erased && (eff != '0);
      default: match = 1'b0;
    endcase
  end

  assign hit = pend && match;

  always_comb begin
    we    = 1'b0;
    waddr = {region_q, idle_m1[SLOT_W-1:0]};
    wdata = id_q;
    if (cmd.op == OP_SAVE) begin
      we = 1'b1;
    end else if (cmd.op == OP_SCAN && mode == M_COPY && hit) begin
      we    = 1'b1;
      waddr = {!region_q, wptr[SLOT_W-1:0]};
      wdata = eff;
    end
  end

  always_comb begin
    stat.kind      = kind_q;
    stat.id_ones   = (id_q == ID_ONES);
    stat.id_zero   = (id_q == '0);
    stat.idle_zero = (idle_q == '0);
    stat.finish    = ((mode == M_IDLE || mode == M_LOOK) && (hit || scan_end))
                  || (mode == M_COUNT && scan_end && !few);
    stat.to_erase  = (mode == M_COPY) && scan_end;
  end

  always_ff @(posedge clk) begin
    vld_q <= vld[raddr];
    unique case (cmd.op)
      OP_LOAD: begin
        kind_q   <= in_kind;
        id_q     <= in_id;
        slot_q   <= in_slot;
        status_q <= ST_OK;
        rslot_q  <= '0;
      end
      OP_FAIL: status_q <= cmd.code;
      OP_SAVE: begin
        rslot_q <= idle_q;
        idx     <= idle_q;
        down    <= 1'b0;
        mode    <= M_IDLE;
      end
      OP_LOOK: begin
        idx      <= top - CNT_W'(1);
        down     <= 1'b1;
        mode     <= M_LOOK;
        status_q <= ST_NOT_FOUND;
      end
      OP_READ: begin
        priority if (slot_q == '0) begin
          status_q <= ST_PARAM;
        end else if (slot_q > occ_q) begin
          status_q <= ST_FULL;
        end else if (slot_q > CNT_W'(SLOTS)) begin
          status_q <= ST_PARAM;
        end else begin
          rslot_q <= slot_q;
        end
      end
      OP_FLUSH: begin
        idx  <= '0;
        down <= 1'b0;
        cnt  <= '0;
        mode <= M_COUNT;
      end
      OP_SCAN: begin
        if (issue) begin
          idx <= down ? idx - CNT_W'(1) : idx + CNT_W'(1);
        end
        pidx <= idx[SLOT_W-1:0];
        unique case (mode)
          M_IDLE: begin
            if (scan_end) begin
              status_q <= ST_FULL;
            end
          end
          M_LOOK: begin
            if (hit) begin
              rslot_q  <= CNT_W'(pidx) + CNT_W'(1);
              status_q <= ST_OK;
            end
          end
          M_COUNT: begin
            if (hit) begin
              cnt <= cnt + CNT_W'(1);
            end
            if (scan_end) begin
              if (few) begin
                // copy the last three quarters into the other region
                mode <= M_COPY;
                idx  <= CNT_W'(SLOTS / 4);
                wptr <= '0;
              end else begin
                status_q <= ST_NO_FLUSH;
              end
            end
          end
          M_COPY: begin
            if (hit) begin
              wptr <= wptr + CNT_W'(1);
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    if (rst) begin
      region_q <= 1'b0;
      occ_q    <= '0;
      idle_q   <= CNT_W'(1);
      vld      <= '0;
      pend     <= 1'b0;
    end else begin
      pend <= (cmd.op == OP_SCAN) && issue;
      if (cmd.op == OP_INC && occ_q < CNT_W'(SLOTS)) begin
        occ_q <= occ_q + CNT_W'(1);
      end
      if (cmd.op == OP_SCAN && mode == M_IDLE) begin
        if (hit) begin
          idle_q <= CNT_W'(pidx) + CNT_W'(1);
        end else if (scan_end) begin
          idle_q <= '0;
        end
      end
      if (cmd.op == OP_ERASE) begin
        // the copied ids sit packed at the bottom of the new region
        if (region_q) begin
          vld[2*SLOTS-1:SLOTS] <= '0;
        end else begin
          vld[SLOTS-1:0] <= '0;
        end
        region_q <= !region_q;
        occ_q    <= wptr;
        idle_q   <= wptr + CNT_W'(1);
      end
      if (we) begin
        vld[waddr] <= 1'b1;
      end
    end
  end

  assign status      = status_q;
  assign result_slot = rslot_q;
  assign region      = region_q;
  assign occupied    = occ_q;
  assign idle        = idle_q;
endmodule
`default_nettype wire

// ===== hw/rtl/frlsm_ctrl.sv =====
// Controller: request sequencing state machine and channel handshakes.
`default_nettype none
module frlsm_ctrl import frlsm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);
  typedef enum logic [2:0] {S_IDLE, S_DECODE, S_SCAN, S_ERASE, S_DONE} state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd.op     = OP_NONE;
    cmd.code   = ST_OK;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_DONE;
        unique case (stat.kind)
          K_SAVE: begin
            priority if (stat.id_ones) begin
              cmd.op   = OP_FAIL;
              cmd.code = ST_PARAM;
            end else if (stat.idle_zero) begin
              cmd.op   = OP_FAIL;
              cmd.code = ST_FULL;
            end else begin
              cmd.op     = OP_SAVE;
              state_next = S_SCAN;
            end
          end
          K_LOOKUP: begin
            if (stat.id_zero) begin
              cmd.op   = OP_FAIL;
              cmd.code = ST_PARAM;
            end else begin
              cmd.op     = OP_LOOK;
              state_next = S_SCAN;
            end
          end
          K_READ: cmd.op = OP_READ;
          K_INC:  cmd.op = OP_INC;
          K_FLUSH: begin
            cmd.op     = OP_FLUSH;
            state_next = S_SCAN;
          end
          default: begin
            cmd.op   = OP_FAIL;
            cmd.code = ST_PARAM;
          end
        endcase
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        priority if (stat.finish) begin
          state_next = S_DONE;
        end else if (stat.to_erase) begin
          state_next = S_ERASE;
        end
      end
      S_ERASE: begin
        cmd.op     = OP_ERASE;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      in_ready  <= (state_next == S_IDLE);
      out_valid <= (state_next == S_DONE);
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/frlsm_checker.sv =====
// Port-level checks of the slot manager, bound to the top level.
`default_nettype none
module frlsm_assert import frlsm_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [STATUS_W-1:0] status,
  input logic [CNT_W-1:0]    result_slot,
  input logic [CNT_W-1:0]    occupied_count,
  input logic [CNT_W-1:0]    next_idle_slot
);
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(result_slot))
    else $error("response beat changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |-> !rsp_valid)
    else $error("request taken while a response is pending");

  a_accept_then_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready && !rsp_valid)
    else $error("no processing cycle after a request");

  a_ranges: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> occupied_count <= CNT_W'(SLOTS) && next_idle_slot <= CNT_W'(SLOTS)
                  && result_slot <= CNT_W'(SLOTS) && status <= STATUS_W'(ST_NO_FLUSH))
    else $error("response field out of range");
endmodule

bind flash_record_log_slot_manager frlsm_assert u_chk (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .status        (rsp.status),
  .result_slot   (rsp.result_slot),
  .occupied_count(rsp.occupied_count),
  .next_idle_slot(rsp.next_idle_slot)
);
`default_nettype wire

// ===== tb/frlsm_checker.sv =====
// Slot map predictor and response scoreboard for the record log slot manager.
`timescale 1ns / 1ps
module frlsm_checker import frlsm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  frlsm_req_if  req,
  frlsm_rsp_if  rsp,
  output int    fail_count,
  output int    pending,
  output int    checked
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    result_slot;
    logic                region;
    logic [CNT_W-1:0]    occupied;
    logic [CNT_W-1:0]    next_idle;
  } slot_rsp_t;

  logic [ID_BITS-1:0] slot_map [0:2*SLOTS-1];
  logic               live;
  int                 occ;
  int                 idle_slot;
  slot_rsp_t          awaited [$];

  function automatic int base_of(logic r);
    return r ? SLOTS : 0;
  endfunction

  // Find the first erased slot at or after 'from' in the live region.
  function automatic bit find_idle(int from);
    int b;
    b = base_of(live);
    for (int s = (from == 0 ? 1 : from); s <= SLOTS; s++) begin
      if (slot_map[b + s - 1] == ID_ONES) begin
        idle_slot = s;
        return 1;
      end
    end
    idle_slot = 0;
    return 0;
  endfunction

  function automatic slot_rsp_t serve_request(logic [KIND_W-1:0] k, logic [31:0] id,
                                              logic [CNT_W-1:0] sl);
    slot_rsp_t r;
    int        b;
    int        top;
    int        erased;
    int        w;
    int        ob;
    logic [ID_BITS-1:0] v;
    r = '0;
    b = base_of(live);
    case (k)
      K_SAVE: begin
        if (id == ID_ONES) r.status = ST_PARAM;
        else if (idle_slot == 0 || idle_slot > SLOTS) r.status = ST_FULL;
        else begin
          r.result_slot = CNT_W'(idle_slot);
          slot_map[b + idle_slot - 1] = id;
          if (!find_idle(idle_slot)) r.status = ST_FULL;
        end
      end
      K_LOOKUP: begin
        if (id == 0) r.status = ST_PARAM;
        else begin
          top = occ > SLOTS ? SLOTS : occ;
          r.status = ST_NOT_FOUND;
          for (int s = top; s >= 1; s--) begin
            if (slot_map[b + s - 1] == id) begin
              r.status = ST_OK;
              r.result_slot = CNT_W'(s);
              break;
            end
          end
        end
      end
      K_READ: begin
        if (sl == 0) r.status = ST_PARAM;
        else if (sl > occ) r.status = ST_FULL;
        else if (sl > SLOTS) r.status = ST_PARAM;
        else r.result_slot = sl;
      end
      K_INC: begin
        if (occ < SLOTS) occ++;
      end
      K_FLUSH: begin
        erased = 0;
        for (int s = 0; s < SLOTS; s++) if (slot_map[b + s] == ID_ONES) erased++;
        if (erased >= SLOTS / 8) r.status = ST_NO_FLUSH;
        else begin
          ob = base_of(!live);
          w = 0;
          // Keep live ids of the last three quarters, packed from slot one.
          for (int s = SLOTS / 4; s < SLOTS; s++) begin
            v = slot_map[b + s];
            if (v != 0 && v != ID_ONES && w < SLOTS) begin
              slot_map[ob + w] = v;
              w++;
            end
          end
          for (int s = 0; s < SLOTS; s++) slot_map[b + s] = ID_ONES;
          live = !live;
          occ = 0;
          for (int s = 1; s <= SLOTS; s++) if (slot_map[ob + s - 1] != ID_ONES) occ = s;
          void'(find_idle(1));
        end
      end
      default: r.status = ST_PARAM;
    endcase
    r.region = live;
    r.occupied = CNT_W'(occ);
    r.next_idle = CNT_W'(idle_slot);
    return r;
  endfunction

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    slot_rsp_t e;
    if (rst) begin
      for (int i = 0; i < 2 * SLOTS; i++) slot_map[i] = ID_ONES;
      live = 0;
      occ = 0;
      idle_slot = 1;
      awaited.delete();
      fail_count = 0;
      checked = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (awaited.size() == 0) begin
          fail_count++;
          $display("%0t: response beat with nothing expected, status %0d", $time,
                   rsp.status);
        end else begin
          e = awaited.pop_front();
          checked++;
          compare_field("status", e.status, rsp.status);
          compare_field("result_slot", e.result_slot, rsp.result_slot);
          compare_field("active_region", e.region, rsp.active_region);
          compare_field("occupied_count", e.occupied, rsp.occupied_count);
          compare_field("next_idle_slot", e.next_idle, rsp.next_idle_slot);
        end
      end
      if (req.valid && req.ready)
        awaited.push_back(serve_request(req.kind, req.record_id, req.slot));
    end
    pending = awaited.size();
  end

endmodule

// ===== tb/flash_record_log_slot_manager_tb.sv =====
// Stimulus, handshake pacing and verdict for the record log slot manager.
`timescale 1ns / 1ps
module flash_record_log_slot_manager_tb;
  import frlsm_pkg::*;

  localparam int RANDOM_ITEMS = 1330;
  localparam int CYCLE_LIMIT  = 1000000;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   checked;
  int   items_sent;
  int   cycles;
  logic [31:0] saved_ids [$];

  frlsm_req_if req ();
  frlsm_rsp_if rsp ();

  flash_record_log_slot_manager dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  frlsm_checker chk (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .fail_count(fail_count), .pending(pending), .checked(checked)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // No idling while a quiet stretch of items is in flight.
  function automatic int idle_pct();
    return (items_sent >= 700 && items_sent < 900) ? 0 : 36;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses pending", cycles, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send(input logic [KIND_W-1:0] k, input logic [31:0] id,
                      input logic [CNT_W-1:0] sl);
    while ($urandom_range(99) < idle_pct()) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.kind      <= k;
    req.record_id <= id;
    req.slot      <= sl;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    items_sent++;
    if (k == K_SAVE && id != '1) begin
      saved_ids.push_back(id);
      if (saved_ids.size() > 16) void'(saved_ids.pop_front());
    end
  endtask

  function automatic logic [31:0] pick_id();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 32'h0;
    if (r < 13) return 32'hFFFF_FFFF;
    if (r < 45 && saved_ids.size() > 0)
      return saved_ids[$urandom_range(saved_ids.size() - 1)];
    return $urandom();
  endfunction

  // Receiver: random back-pressure plus one long hold-off.
  initial begin
    bit held;
    held = 0;
    rsp.ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!held && items_sent >= 300) begin
        held = 1;
        rsp.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      rsp.ready <= ($urandom_range(99) >= idle_pct());
    end
  end

  initial begin
    int r;
    logic [KIND_W-1:0] k;
    items_sent = 0;
    rst = 1'b1;
    req.valid <= 1'b0;
    req.kind <= K_SAVE;
    req.record_id <= '0;
    req.slot <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners.
    send(K_SAVE, 32'hFFFF_FFFF, '0);
    send(K_SAVE, 32'h0, '0);
    send(K_SAVE, 32'hFFFF_FFFE, '0);
    send(K_SAVE, 32'h1234_5678, '0);
    send(K_LOOKUP, 32'h0, '0);
    send(K_LOOKUP, 32'h1234_5678, '0);
    send(K_LOOKUP, 32'h0000_0001, '0);
    send(K_LOOKUP, 32'hFFFF_FFFE, '0);
    send(K_READ, 32'h0, '0);
    send(K_READ, 32'h0, 7'd1);
    send(K_READ, 32'h0, 7'd3);
    send(K_READ, 32'h0, 7'd4);
    send(K_READ, 32'h0, 7'h7F);
    send(K_INC, 32'h0, '0);
    send(K_INC, 32'h0, '0);
    send(K_LOOKUP, 32'hFFFF_FFFF, '0);
    send(K_READ, 32'h0, 7'd5);
    send(K_FLUSH, 32'h0, '0);
    send(3'd5, 32'h0, '0);
    send(3'd6, 32'hFFFF_FFFF, 7'h7F);
    send(3'd7, 32'h0, '0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 1000) begin
        // Pause until the block has answered everything.
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      r = $urandom_range(99);
      if (r < 46) k = K_SAVE;
      else if (r < 70) k = K_LOOKUP;
      else if (r < 80) k = K_READ;
      else if (r < 86) k = K_INC;
      else if (r < 97) k = K_FLUSH;
      else k = KIND_W'($urandom_range(7, 5));
      send(k, pick_id(),
           CNT_W'(($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(65)));
    end
    req.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d requests, checked %0d responses across fills, lookups and flushes",
             items_sent, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
